// ===== rtl/pbd_pkg.sv =====
// Shared types, constants and the arctangent table for the bearing pipeline.
package pbd_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int COORD_BITS_DEF   = 16;
   localparam int ATAN_ENTRIES     = 24;

   localparam int WORK_BITS = 40;
   localparam int VEC_W     = 44;
   localparam int ANG_W     = 27;
   localparam int BEAR_W    = 17;

   localparam logic signed [ANG_W-1:0] DEG180_Q16 = ANG_W'(180 * 65536);
   localparam logic signed [ANG_W-1:0] DEG360_Q16 = ANG_W'(360 * 65536);
   localparam logic [BEAR_W:0]         DEG360_Q8  = (BEAR_W+1)'(92160);
   localparam logic [ANG_W-1:0]        ROUND_HALF = ANG_W'(128);

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] ang;
      logic                    zero;
   } vec_type;

   // atan(2^-i) in degrees, Q.16, rounded to nearest
   function automatic logic signed [ANG_W-1:0] atan_q16(input int idx);
      logic signed [ANG_W-1:0] r;
      begin
         case (idx)
            0:       r = ANG_W'(2949120);
            1:       r = ANG_W'(1740967);
            2:       r = ANG_W'(919879);
            3:       r = ANG_W'(466945);
            4:       r = ANG_W'(234379);
            5:       r = ANG_W'(117304);
            6:       r = ANG_W'(58666);
            7:       r = ANG_W'(29335);
            8:       r = ANG_W'(14668);
            9:       r = ANG_W'(7334);
            10:      r = ANG_W'(3667);
            11:      r = ANG_W'(1833);
            12:      r = ANG_W'(917);
            13:      r = ANG_W'(458);
            14:      r = ANG_W'(229);
            15:      r = ANG_W'(115);
            16:      r = ANG_W'(57);
            17:      r = ANG_W'(29);
            18:      r = ANG_W'(14);
            19:      r = ANG_W'(7);
            20:      r = ANG_W'(4);
            21:      r = ANG_W'(2);
            22:      r = ANG_W'(1);
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== rtl/planar_bearing_degrees_core.sv =====
// Top level: pipelined CORDIC bearing from a source point to a target point.
//
// Input channel req_*: four signed Q8.8 coordinates (from_x, from_z, to_x, to_z)
// per transfer. Result channel rsp_*: bearing in unsigned Q9.8 degrees,
// 0 up to under 360, and zero_vector, set when both points coincide in XZ
// (bearing is then 0).
// From input transfer to rsp_valid an item passes one entry stage, one
// register stage per CORDIC iteration and one output stage.
// One item per cycle while rsp_ready is high; each stage has its own valid bit.
// When rsp_ready is low, the output stage holds its result and stages behind
// it keep filling until the first full stage is reached, so req_ready drops
// only once every stage holds an item. Nothing is dropped or repeated.
// Synchronous reset clears all valid bits; no result is pending afterward.
module planar_bearing_degrees_core #(
   parameter int CORDIC_STEPS = pbd_pkg::CORDIC_STEPS_DEF,
   parameter int COORD_BITS   = pbd_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_from_x,
   input  logic signed [COORD_BITS-1:0] req_from_z,
   input  logic signed [COORD_BITS-1:0] req_to_x,
   input  logic signed [COORD_BITS-1:0] req_to_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [pbd_pkg::BEAR_W-1:0]   rsp_bearing,
   output logic                         rsp_zero_vector
);

   pbd_pkg::vec_type vec   [0:CORDIC_STEPS];
   logic             vld   [0:CORDIC_STEPS];
   logic             rdy   [0:CORDIC_STEPS];

   pbd_prep #(
      .COORD_BITS (COORD_BITS)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_ready   (req_ready),
      .from_x     (req_from_x),
      .from_z     (req_from_z),
      .to_x       (req_to_x),
      .to_z       (req_to_z),
      .down_valid (vld[0]),
      .down_ready (rdy[0]),
      .down_vec   (vec[0])
   );

   for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
      pbd_cordic_stage #(
         .STEP (s)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (vld[s]),
         .up_ready   (rdy[s]),
         .up_vec     (vec[s]),
         .down_valid (vld[s+1]),
         .down_ready (rdy[s+1]),
         .down_vec   (vec[s+1])
      );
   end

   pbd_finish u_finish (
      .clock           (clock),
      .reset           (reset),
      .up_valid        (vld[CORDIC_STEPS]),
      .up_ready        (rdy[CORDIC_STEPS]),
      .up_vec          (vec[CORDIC_STEPS]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bearing     (rsp_bearing),
      .rsp_zero_vector (rsp_zero_vector)
   );

endmodule

// ===== rtl/pbd_prep.sv =====
// Entry stage: difference vector, zero detect, scaling and right half plane fold.
module pbd_prep #(
   parameter int COORD_BITS = pbd_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         up_valid,
   output logic                         up_ready,
   input  logic signed [COORD_BITS-1:0] from_x,
   input  logic signed [COORD_BITS-1:0] from_z,
   input  logic signed [COORD_BITS-1:0] to_x,
   input  logic signed [COORD_BITS-1:0] to_z,
   output logic                         down_valid,
   input  logic                         down_ready,
   output pbd_pkg::vec_type             down_vec
);

   localparam int SHIFT = pbd_pkg::WORK_BITS - COORD_BITS;

   logic                            valid_ff;
   pbd_pkg::vec_type                vec_ff, vec_in;
   logic signed [COORD_BITS:0]      dx, dz;
   logic signed [pbd_pkg::VEC_W-1:0] sx, sz;

   always_comb begin
      dx = (COORD_BITS+1)'(to_x) - (COORD_BITS+1)'(from_x);
      dz = (COORD_BITS+1)'(to_z) - (COORD_BITS+1)'(from_z);
      sx = pbd_pkg::VEC_W'(dx) <<< SHIFT;
      sz = pbd_pkg::VEC_W'(dz) <<< SHIFT;
      vec_in.zero = (dx == '0) && (dz == '0);
      if (dx[COORD_BITS]) begin
         vec_in.x   = -sx;
         vec_in.y   = -sz;
         vec_in.ang = pbd_pkg::DEG180_Q16;
      end else begin
         vec_in.x   = sx;
         vec_in.y   = sz;
         vec_in.ang = '0;
      end
   end

   assign up_ready   = !valid_ff || down_ready;
   assign down_valid = valid_ff;
   assign down_vec   = vec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         vec_ff <= vec_in;
      end
   end

endmodule

// ===== rtl/pbd_cordic_stage.sv =====
// One registered CORDIC vectoring iteration.
module pbd_cordic_stage #(
   parameter int STEP = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             up_valid,
   output logic             up_ready,
   input  pbd_pkg::vec_type up_vec,
   output logic             down_valid,
   input  logic             down_ready,
   output pbd_pkg::vec_type down_vec
);

   localparam logic signed [pbd_pkg::ANG_W-1:0] ATAN = pbd_pkg::atan_q16(STEP);

   logic                             valid_ff;
   pbd_pkg::vec_type                 vec_ff, vec_in;
   logic signed [pbd_pkg::VEC_W-1:0] xs, ys;

   always_comb begin
      xs = up_vec.x >>> STEP;
      ys = up_vec.y >>> STEP;
      vec_in.zero = up_vec.zero;
      if (!up_vec.y[pbd_pkg::VEC_W-1]) begin
         vec_in.x   = up_vec.x + ys;
         vec_in.y   = up_vec.y - xs;
         vec_in.ang = up_vec.ang + ATAN;
      end else begin
         vec_in.x   = up_vec.x - ys;
         vec_in.y   = up_vec.y + xs;
         vec_in.ang = up_vec.ang - ATAN;
      end
   end

   assign up_ready   = !valid_ff || down_ready;
   assign down_valid = valid_ff;
   assign down_vec   = vec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         vec_ff <= vec_in;
      end
   end

endmodule

// ===== rtl/pbd_finish.sv =====
// Output stage: fold into [0, 360), round to Q9.8, wrap, zero vector override.
module pbd_finish (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        up_valid,
   output logic                        up_ready,
   input  pbd_pkg::vec_type            up_vec,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pbd_pkg::BEAR_W-1:0]  rsp_bearing,
   output logic                        rsp_zero_vector
);

   localparam int AW = pbd_pkg::ANG_W;
   localparam int BW = pbd_pkg::BEAR_W;

   logic          valid_ff;
   logic [BW-1:0] bearing_ff, bearing_in;
   logic          zero_ff;
   logic [AW-1:0] folded, rounded;
   logic [BW:0]   q8;

   always_comb begin
      if (up_vec.ang[AW-1]) begin
         folded = AW'(up_vec.ang + pbd_pkg::DEG360_Q16);
      end else begin
         folded = AW'(up_vec.ang);
      end
      rounded = folded + pbd_pkg::ROUND_HALF;
      q8      = rounded[BW+8:8];
      if (q8 >= pbd_pkg::DEG360_Q8) begin
         q8 = q8 - pbd_pkg::DEG360_Q8;
      end
      bearing_in = up_vec.zero ? '0 : q8[BW-1:0];
   end

   assign up_ready        = !valid_ff || rsp_ready;
   assign rsp_valid       = valid_ff;
   assign rsp_bearing     = bearing_ff;
   assign rsp_zero_vector = zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         bearing_ff <= bearing_in;
         zero_ff    <= up_vec.zero;
      end
   end

endmodule
